### src/pbrs_pkg.sv
// Shared widths and command codes of the priority bitmap ready scheduler.
`timescale 1ns / 1ps
package pbrs_pkg;

  localparam int TASK_W     = 8;
  localparam int PRIO_W     = 8;
  localparam int SEL_PRIO_W = 5;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_SCHED = 1'b1;

endpackage

### src/pbrs_if.sv
// Valid/ready channel interfaces for command words and result words.
`timescale 1ns / 1ps
interface pbrs_req_if import pbrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [TASK_W-1:0] task_id;
  logic [PRIO_W-1:0] priority_req;
  logic              current_running;

  modport source (output valid, command, task_id, priority_req, current_running,
                  input ready);
  modport sink   (input valid, command, task_id, priority_req, current_running,
                  output ready);
endinterface

interface pbrs_rsp_if import pbrs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  selected_valid;
  logic [TASK_W-1:0]     selected_task;
  logic [SEL_PRIO_W-1:0] selected_priority;
  logic                  first_start;
  logic                  switch_request;
  logic                  overflow;

  modport source (output valid, selected_valid, selected_task, selected_priority,
                  first_start, switch_request, overflow, input ready);
  modport sink   (input valid, selected_valid, selected_task, selected_priority,
                  first_start, switch_request, overflow, output ready);
endinterface

### src/priority_bitmap_ready_scheduler.sv
// Priority bitmap scheduler with one FIFO of task ids per level, kept in memories.
//
//   Channel | Dir | Payload
//   req     | in  | command, task_id, priority_req, current_running
//   rsp     | out | selected_valid, selected_task, selected_priority,
//           |     | first_start, switch_request, overflow
//
// An add word passes S_IDLE and S_META; a schedule word passes S_IDLE, S_META and
// S_POP, and S_PUSH when the running task is requeued; a schedule on an empty
// bitmap ends in S_IDLE. Level table and queue memory reads are registered.
// Reset is synchronous; per-level valid bits stand in for clearing the table.
// A result waits in the output register while rsp stalls; a further word is
// still accepted, and its result waits until the register frees.
`timescale 1ns / 1ps
module priority_bitmap_ready_scheduler
  import pbrs_pkg::*;
#(
  parameter int NUM_LEVELS    = 32,
  parameter int LEVEL_DEPTH   = 16,
  parameter int TASK_ID_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  pbrs_req_if.sink   req,
  pbrs_rsp_if.source rsp
);

  localparam int LW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int HW  = $clog2(LEVEL_DEPTH);
  localparam int CW  = $clog2(LEVEL_DEPTH + 1);
  localparam int SW  = CW + 1;
  localparam int MW  = HW + CW;
  localparam int QN  = NUM_LEVELS * LEVEL_DEPTH;
  localparam int QAW = $clog2(QN);
  localparam int IDW = TASK_ID_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_META = 5'b00010,
    S_POP  = 5'b00100,
    S_PUSH = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  typedef struct packed {
    logic                  sel_valid;
    logic [TASK_W-1:0]     sel_task;
    logic [SEL_PRIO_W-1:0] sel_prio;
    logic                  first;
    logic                  sw;
    logic                  ovf;
  } result_t;

  state_t state, state_next;

  logic [NUM_LEVELS-1:0] bitmap, bitmap_next;
  logic [NUM_LEVELS-1:0] meta_vld;
  logic [IDW-1:0]        cur_task;
  logic                  cur_valid;

  logic           cmd_r;
  logic [IDW-1:0] id_r;
  logic [LW-1:0]  plvl_r;
  logic [LW-1:0]  lvl_r;
  logic           run_r;
  result_t        res_r;

  logic [MW-1:0]  meta_mem [NUM_LEVELS];
  logic [MW-1:0]  meta_rd_data;
  logic           meta_rd_vld;
  logic [LW-1:0]  meta_raddr;
  logic           meta_we;
  logic [LW-1:0]  meta_waddr;
  logic [MW-1:0]  meta_wdata;

  logic [IDW-1:0] q_mem [QN];
  logic [IDW-1:0] q_rd_data;
  logic [QAW-1:0] q_raddr;
  logic           q_we;
  logic [QAW-1:0] q_waddr;

  logic [LW-1:0]  in_lvl;
  logic [LW-1:0]  top_lvl;
  logic [HW-1:0]  m_head;
  logic [CW-1:0]  m_count;
  logic [HW-1:0]  head_inc;
  logic [SW-1:0]  slot_sum;
  logic [HW-1:0]  slot;
  logic           full;
  logic           out_free;
  logic           fin_go;
  result_t        fin;

  assign req.ready = (state == S_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;

  assign in_lvl = (req.priority_req >= PRIO_W'(NUM_LEVELS)) ? LW'(NUM_LEVELS - 1)
                                                            : LW'(req.priority_req);

  always_comb begin
    top_lvl = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (bitmap[i]) begin
        top_lvl = LW'(i);
      end
    end
  end

  assign m_head   = meta_rd_vld ? meta_rd_data[MW-1:CW] : '0;
  assign m_count  = meta_rd_vld ? meta_rd_data[CW-1:0] : '0;
  assign head_inc = (m_head == HW'(LEVEL_DEPTH - 1)) ? '0 : m_head + 1'b1;
  assign slot_sum = SW'(m_head) + SW'(m_count);
  assign slot     = (slot_sum >= SW'(LEVEL_DEPTH)) ? HW'(slot_sum - SW'(LEVEL_DEPTH))
                                                    : HW'(slot_sum);
  assign full     = (m_count == CW'(LEVEL_DEPTH));
  assign q_waddr  = QAW'(LEVEL_DEPTH) * QAW'(plvl_r) + QAW'(slot);
  assign q_raddr  = QAW'(LEVEL_DEPTH) * QAW'(lvl_r) + QAW'(m_head);

  always_comb begin
    state_next  = state;
    bitmap_next = bitmap;
    meta_raddr  = plvl_r;
    meta_we     = 1'b0;
    meta_waddr  = plvl_r;
    meta_wdata  = '0;
    q_we        = 1'b0;
    fin         = '0;
    fin_go      = 1'b0;
    unique case (state)
      S_IDLE: begin
        meta_raddr = (req.command == CMD_SCHED) ? top_lvl : in_lvl;
        if (req.valid) begin
          if (req.command == CMD_SCHED && bitmap == '0) begin
            fin_go = 1'b1;
          end else begin
            state_next = S_META;
          end
        end
      end
      S_META: begin
        if (cmd_r == CMD_ADD) begin
          if (full) begin
            fin.ovf = 1'b1;
          end else begin
            q_we                = 1'b1;
            meta_we             = 1'b1;
            meta_wdata          = {m_head, m_count + 1'b1};
            bitmap_next[plvl_r] = 1'b1;
          end
          fin_go = 1'b1;
        end else begin
          meta_we    = 1'b1;
          meta_waddr = lvl_r;
          meta_wdata = {head_inc, m_count - 1'b1};
          if (m_count == CW'(1)) begin
            bitmap_next[lvl_r] = 1'b0;
          end
          state_next = S_POP;
        end
      end
      S_POP: begin
        fin.sel_valid = 1'b1;
        fin.sel_task  = TASK_W'(q_rd_data);
        fin.sel_prio  = SEL_PRIO_W'(lvl_r);
        fin.first     = !cur_valid;
        fin.sw        = cur_valid;
        if (cur_valid && run_r) begin
          state_next = S_PUSH;
        end else begin
          fin_go = 1'b1;
        end
      end
      S_PUSH: begin
        fin = res_r;
        if (full) begin
          fin.ovf = 1'b1;
        end else begin
          q_we                = 1'b1;
          meta_we             = 1'b1;
          meta_wdata          = {m_head, m_count + 1'b1};
          bitmap_next[plvl_r] = 1'b1;
        end
        fin_go = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin_go) begin
      state_next = out_free ? S_IDLE : S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    meta_rd_data <= meta_mem[meta_raddr];
    meta_rd_vld  <= meta_vld[meta_raddr];
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
  end

  always_ff @(posedge clk) begin
    q_rd_data <= q_mem[q_raddr];
    if (q_we) begin
      q_mem[q_waddr] <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      cmd_r  <= req.command;
      id_r   <= IDW'(req.task_id);
      plvl_r <= in_lvl;
      lvl_r  <= top_lvl;
      run_r  <= req.current_running;
    end
    if (state == S_POP) begin
      id_r <= cur_task;
    end
    if (state == S_POP || (fin_go && !out_free)) begin
      res_r <= fin;
    end
    if (fin_go && out_free) begin
      rsp.selected_valid    <= fin.sel_valid;
      rsp.selected_task     <= fin.sel_task;
      rsp.selected_priority <= fin.sel_prio;
      rsp.first_start       <= fin.first;
      rsp.switch_request    <= fin.sw;
      rsp.overflow          <= fin.ovf;
    end else if (state == S_DONE && out_free) begin
      rsp.selected_valid    <= res_r.sel_valid;
      rsp.selected_task     <= res_r.sel_task;
      rsp.selected_priority <= res_r.sel_prio;
      rsp.first_start       <= res_r.first;
      rsp.switch_request    <= res_r.sw;
      rsp.overflow          <= res_r.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bitmap    <= '0;
      meta_vld  <= '0;
      cur_task  <= '0;
      cur_valid <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state  <= state_next;
      bitmap <= bitmap_next;
      if (meta_we) begin
        meta_vld[meta_waddr] <= 1'b1;
      end
      if (state == S_POP) begin
        cur_task  <= q_rd_data;
        cur_valid <= 1'b1;
      end
      if ((fin_go || state == S_DONE) && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

### src/pbrs_checker.sv
// Port-level checks of the scheduler, bound to its top level.
`timescale 1ns / 1ps
module pbrs_sva_checker
  import pbrs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  selected_valid,
  input logic [TASK_W-1:0]     selected_task,
  input logic [SEL_PRIO_W-1:0] selected_priority,
  input logic                  first_start,
  input logic                  switch_request,
  input logic                  overflow
);

  logic picked_before;

  always_ff @(posedge clk) begin
    if (rst) begin
      picked_before <= 1'b0;
    end else if (out_valid && out_ready && selected_valid) begin
      picked_before <= 1'b1;
    end
  end

  a_pick_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (selected_valid ? (first_start != switch_request)
                                  : (!first_start && !switch_request &&
                                     selected_task == '0 && selected_priority == '0)))
    else $error("Pick flags disagree with selected_valid.");

  a_first_once: assert property (@(posedge clk) disable iff (rst)
    out_valid && selected_valid |-> (first_start == !picked_before))
    else $error("first_start does not mark exactly the first pick.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (!out_valid || out_ready) |=> out_valid || !in_ready)
    else $error("A second word was taken while one was in flight.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(selected_valid) &&
      $stable(selected_task) && $stable(selected_priority) &&
      $stable(first_start) && $stable(switch_request) && $stable(overflow))
    else $error("Result word changed while stalled.");

endmodule

bind priority_bitmap_ready_scheduler pbrs_sva_checker u_pbrs_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (req.valid),
  .in_ready          (req.ready),
  .out_valid         (rsp.valid),
  .out_ready         (rsp.ready),
  .selected_valid    (rsp.selected_valid),
  .selected_task     (rsp.selected_task),
  .selected_priority (rsp.selected_priority),
  .first_start       (rsp.first_start),
  .switch_request    (rsp.switch_request),
  .overflow          (rsp.overflow)
);
